// ===== src/calendar_date_step_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Calendar date step counter assertion macros
// Shared assertion forms for the modules of the date counter.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("date counter check failed");

// Next-cycle implication, checked outside reset.
`define CDSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date counter check failed");

`endif

// ===== src/cdsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date step counter package
// Operation and relation codes, sequencer states and calendar helpers.
// ----------------------------------------------------------------------------
package cdsc_pkg;

  localparam int unsigned LeapCycle = 400;
  localparam int unsigned Century   = 100;
  localparam int unsigned MonthsC   = 12;
  localparam int unsigned ResW      = 9;

  localparam logic [4:0] Days28 = 5'd28;
  localparam logic [4:0] Days29 = 5'd29;
  localparam logic [4:0] Days30 = 5'd30;
  localparam logic [4:0] Days31 = 5'd31;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADD     = 2'd1,
    OP_SUB     = 2'd2,
    OP_COMPARE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REL_EQUAL   = 2'd0,
    REL_LATER   = 2'd1,
    REL_EARLIER = 2'd2
  } rel_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_STEP = 3'b100
  } state_e;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
  } date_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == 4'd2) begin
      len = leap ? Days29 : Days28;
    end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      len = Days30;
    end else begin
      len = Days31;
    end
    return len;
  endfunction

  function automatic logic [4:0] prev_month_end(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == 4'd3) begin
      len = leap ? Days29 : Days28;
    end else if (month == 4'd1 || month == 4'd2 || month == 4'd4 || month == 4'd6 ||
                 month == 4'd8 || month == 4'd9 || month == 4'd11) begin
      len = Days31;
    end else begin
      len = Days30;
    end
    return len;
  endfunction

endpackage

// ===== src/cdsc_mod400.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Year residue unit
// Remainder of a year by the leap cycle in two register stages: the year over
// sixteen is folded in ten-bit digits, reduced by a reciprocal multiply, and
// joined with the low four year bits.
// ----------------------------------------------------------------------------
module cdsc_mod400 #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [YEAR_BITS-1:0]       value_i,
  output logic                       done_o,
  output logic [cdsc_pkg::ResW-1:0]  rem_o
);

  localparam int unsigned Base   = cdsc_pkg::LeapCycle / 16;
  localparam int unsigned DigitW = 10;
  localparam int unsigned SumW   = 12;
  localparam int unsigned Shift  = 17;
  localparam int unsigned RecipW = 13;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned Recip  = ((1 << Shift) + Base - 1) / Base;
  localparam int unsigned Bias   = (((1 << DigitW) + Base - 1) / Base) * Base;

  logic [31:0]               year_w;
  logic [SumW-1:0]           sum_q, sum_d;
  logic [3:0]                low_q, low_d;
  logic                      sum_vld_q;
  logic                      done_q;
  logic [7:0]                quot;
  logic [4:0]                rem25;
  logic [cdsc_pkg::ResW-1:0] rem_q, rem_d;

  // Since 1024 is one less than a multiple of 25, the ten-bit digits of the
  // year over sixteen alternate in sign modulo 25.
  assign year_w = 32'(value_i);
  assign sum_d  = SumW'(year_w[13:4]) + SumW'(year_w[31:24]) + SumW'(Bias) -
                  SumW'(year_w[23:14]);
  assign low_d  = year_w[3:0];

  assign quot  = 8'((ProdW'(sum_q) * ProdW'(Recip)) >> Shift);
  assign rem25 = 5'(sum_q - SumW'(quot) * SumW'(Base));
  assign rem_d = {rem25, low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      sum_vld_q <= start_i;
      done_q    <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
      low_q <= low_d;
    end
    if (sum_vld_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/cdsc_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day step unit
// Moves a date one day forward or back and keeps the year residue in step.
// ----------------------------------------------------------------------------
module cdsc_step_unit #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic                       back_i,
  input  cdsc_pkg::date_t            date_i,
  input  logic [YEAR_BITS-1:0]       year_i,
  input  logic [cdsc_pkg::ResW-1:0]  res_i,
  output cdsc_pkg::date_t            date_o,
  output logic [YEAR_BITS-1:0]       year_o,
  output logic [cdsc_pkg::ResW-1:0]  res_o
);

  localparam longint unsigned YearMax = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [cdsc_pkg::ResW-1:0] ResTop =
    cdsc_pkg::ResW'(YearMax % 64'(cdsc_pkg::LeapCycle));
  localparam logic [cdsc_pkg::ResW-1:0] ResLast =
    cdsc_pkg::ResW'(cdsc_pkg::LeapCycle - 1);

  logic       leap;
  logic [3:0] month_inc;
  logic       yr_up, yr_dn;

  assign leap = (year_i[1:0] == 2'b00) &&
                (res_i != cdsc_pkg::ResW'(cdsc_pkg::Century)) &&
                (res_i != cdsc_pkg::ResW'(2 * cdsc_pkg::Century)) &&
                (res_i != cdsc_pkg::ResW'(3 * cdsc_pkg::Century));

  assign month_inc = date_i.month + 4'd1;

  always_comb begin
    date_o = date_i;
    yr_up  = 1'b0;
    yr_dn  = 1'b0;
    if (!back_i) begin
      if (date_i.day >= cdsc_pkg::month_len(date_i.month, leap)) begin
        date_o.day = 5'd1;
        if (month_inc > 4'(cdsc_pkg::MonthsC) || month_inc == 4'd0) begin
          date_o.month = 4'd1;
          yr_up        = 1'b1;
        end else begin
          date_o.month = month_inc;
        end
      end else begin
        date_o.day = date_i.day + 5'd1;
      end
    end else begin
      if (date_i.day > 5'd1) begin
        date_o.day = date_i.day - 5'd1;
      end else begin
        date_o.day = cdsc_pkg::prev_month_end(date_i.month, leap);
        if (date_i.month > 4'd1) begin
          date_o.month = date_i.month - 4'd1;
        end else begin
          date_o.month = 4'(cdsc_pkg::MonthsC);
          yr_dn        = 1'b1;
        end
      end
    end
  end

  always_comb begin
    year_o = year_i;
    res_o  = res_i;
    if (yr_up) begin
      year_o = year_i + 1'b1;
      if (year_i == {YEAR_BITS{1'b1}} || res_i == ResLast) begin
        res_o = '0;
      end else begin
        res_o = res_i + 1'b1;
      end
    end else if (yr_dn) begin
      year_o = year_i - 1'b1;
      if (year_i == '0) begin
        res_o = ResTop;
      end else if (res_i == '0) begin
        res_o = ResLast;
      end else begin
        res_o = res_i - 1'b1;
      end
    end
  end

endmodule

// ===== src/calendar_date_step_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date step counter
// Holds one Gregorian date and loads, steps, or compares it on command.
// ----------------------------------------------------------------------------
// Usage: drive operation_i and the given fields with start_i high. An item is
// taken at a rising edge with start_i high and busy_o low. busy_o stays high
// while a load, add or subtract is worked on, and no new item is taken then.
// Each item gives one result: valid_o is high for exactly one cycle while
// current_day_o, current_month_o, current_year_o and relation_o hold it.
// The receiver cannot hold a result off; it must take it in that cycle.
// Timing: a compare gives its result in the cycle after it is taken. An add or
// subtract of N days moves the date one day step per cycle through the shared
// step unit, then shows its result. A load waits on the two register stages
// of the residue unit that finds the year modulo 400.
// A new item may be taken in the cycle in which the previous result shows.
// Reset sets the date to 1 January 2000 and clears busy_o and valid_o.
// ----------------------------------------------------------------------------
`include "calendar_date_step_counter_defines.svh"

module calendar_date_step_counter #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [4:0]  given_day_i,
  input  logic [3:0]  given_month_i,
  input  logic [15:0] given_year_i,
  input  logic [15:0] day_count_i,
  output logic        valid_o,
  output logic [4:0]  current_day_o,
  output logic [3:0]  current_month_o,
  output logic [15:0] current_year_o,
  output logic [1:0]  relation_o
);

  localparam longint unsigned YearMax = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [YEAR_BITS-1:0] YearRst = YEAR_BITS'(64'd2000 & YearMax);
  localparam logic [cdsc_pkg::ResW-1:0] ResRst =
    cdsc_pkg::ResW'((64'd2000 & YearMax) % 64'(cdsc_pkg::LeapCycle));

  cdsc_pkg::state_e          state_q, state_d;
  cdsc_pkg::date_t           date_q, date_d, step_date;
  logic [YEAR_BITS-1:0]      year_q, year_d, step_year, given_year;
  logic [cdsc_pkg::ResW-1:0] res_q, res_d, step_res, mod_rem;
  logic [15:0]               cnt_q, cnt_d;
  logic                      back_q, back_d;
  logic                      valid_q, valid_d;
  cdsc_pkg::rel_e            rel_q, rel_d, rel_cmp;
  logic                      mod_start, mod_done;

  assign given_year = YEAR_BITS'(given_year_i);

  cdsc_mod400 #(
    .YEAR_BITS(YEAR_BITS)
  ) u_mod400 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .value_i(given_year),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  cdsc_step_unit #(
    .YEAR_BITS(YEAR_BITS)
  ) u_step (
    .back_i(back_q),
    .date_i(date_q),
    .year_i(year_q),
    .res_i (res_q),
    .date_o(step_date),
    .year_o(step_year),
    .res_o (step_res)
  );

  always_comb begin
    if (year_q != given_year) begin
      rel_cmp = (year_q > given_year) ? cdsc_pkg::REL_LATER : cdsc_pkg::REL_EARLIER;
    end else if (date_q.month != given_month_i) begin
      rel_cmp = (date_q.month > given_month_i) ? cdsc_pkg::REL_LATER
                                               : cdsc_pkg::REL_EARLIER;
    end else if (date_q.day != given_day_i) begin
      rel_cmp = (date_q.day > given_day_i) ? cdsc_pkg::REL_LATER : cdsc_pkg::REL_EARLIER;
    end else begin
      rel_cmp = cdsc_pkg::REL_EQUAL;
    end
  end

  always_comb begin
    state_d   = state_q;
    date_d    = date_q;
    year_d    = year_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    back_d    = back_q;
    rel_d     = rel_q;
    valid_d   = 1'b0;
    mod_start = 1'b0;
    unique case (state_q)
      cdsc_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (cdsc_pkg::op_e'(operation_i))
            cdsc_pkg::OP_LOAD: begin
              date_d.day   = given_day_i;
              date_d.month = given_month_i;
              year_d       = given_year;
              rel_d        = cdsc_pkg::REL_EQUAL;
              mod_start    = 1'b1;
              state_d      = cdsc_pkg::ST_LOAD;
            end
            cdsc_pkg::OP_ADD, cdsc_pkg::OP_SUB: begin
              cnt_d   = day_count_i;
              back_d  = (cdsc_pkg::op_e'(operation_i) == cdsc_pkg::OP_SUB);
              rel_d   = cdsc_pkg::REL_EQUAL;
              state_d = cdsc_pkg::ST_STEP;
            end
            cdsc_pkg::OP_COMPARE: begin
              rel_d   = rel_cmp;
              valid_d = 1'b1;
            end
            default: begin
              state_d = cdsc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cdsc_pkg::ST_LOAD: begin
        if (mod_done) begin
          res_d   = mod_rem;
          valid_d = 1'b1;
          state_d = cdsc_pkg::ST_IDLE;
        end
      end
      cdsc_pkg::ST_STEP: begin
        if (cnt_q == '0) begin
          valid_d = 1'b1;
          state_d = cdsc_pkg::ST_IDLE;
        end else begin
          date_d = step_date;
          year_d = step_year;
          res_d  = step_res;
          cnt_d  = cnt_q - 16'd1;
        end
      end
      default: begin
        state_d = cdsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cdsc_pkg::ST_IDLE;
      date_q.day   <= 5'd1;
      date_q.month <= 4'd1;
      year_q       <= YearRst;
      res_q        <= ResRst;
      valid_q      <= 1'b0;
      rel_q        <= cdsc_pkg::REL_EQUAL;
    end else begin
      state_q <= state_d;
      date_q  <= date_d;
      year_q  <= year_d;
      res_q   <= res_d;
      valid_q <= valid_d;
      rel_q   <= rel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    back_q <= back_d;
  end

  assign busy_o          = (state_q != cdsc_pkg::ST_IDLE);
  assign valid_o         = valid_q;
  assign current_day_o   = date_q.day;
  assign current_month_o = date_q.month;
  assign current_year_o  = 16'(year_q);
  assign relation_o      = rel_q;

  `CDSC_ASSERT_NOW(a_valid_idle, valid_q, state_q == cdsc_pkg::ST_IDLE)
  `CDSC_ASSERT_NEXT(a_accept_moves, start_i && !busy_o, valid_q || busy_o)
  `CDSC_ASSERT_NEXT(a_load_done, state_q == cdsc_pkg::ST_LOAD && mod_done, valid_q && !busy_o)
  `CDSC_ASSERT_NEXT(a_step_done, state_q == cdsc_pkg::ST_STEP && cnt_q == '0, valid_q && !busy_o)
  `CDSC_ASSERT_NOW(a_rel_code, 1'b1, rel_q != cdsc_pkg::rel_e'(2'b11))

endmodule
